FILE: rtl/core/wip_pkg.sv
// Shared constants, codes and types of the wave interference pixel core.
package wip_pkg;

	localparam int MAX_SOURCES  = 8;
	localparam int TABLE_DEPTH  = 256;

	localparam int SRC_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
	localparam int TBL_AW  = $clog2(TABLE_DEPTH);
	localparam int SLOT_W  = 8;
	localparam int HVAL_W  = 9;
	localparam int COORD_W = 10;
	localparam int NSRC_W  = 4;
	localparam int RAD_W   = 9;
	localparam int CFG_W   = 9;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int D2_W    = SQ_W + 1;
	localparam int ROOT_W  = (D2_W + 1) / 2;
	localparam int STEP_W  = $clog2(ROOT_W + 1);
	localparam int SUM_W   = HVAL_W + CNT_W;
	localparam int LEVEL_W = 8;

	// Scaling: level = min(255, floor(2*sum/5))
	localparam int LEVEL_MAX = 255;
	localparam int SAT_SUM   = 638;
	localparam int RECIP_5   = 13108;
	localparam int RECIP_SH  = 16;

	typedef enum logic [1:0] {
		ACT_HEIGHT = 2'd0,
		ACT_SOURCE = 2'd1,
		ACT_PIXEL  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic {
		CFG_NUM_SOURCES = 1'b0,
		CFG_WAVE_RADIUS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROOT,
		ST_ACC,
		ST_FIN
	} state_t;

	// Broadcast controls of the source cell chain
	typedef struct packed {
		logic                calc;
		logic                shift;
		logic [COORD_W-1:0]  px;
		logic [COORD_W-1:0]  py;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/wave_interference_pixel_core.sv
// Top level: source cell chain, shared root unit, height table and accumulator.
// A pixel runs, per active source (N, at most 8), a start, 11 root steps, a done
// and an add, then a finish state that loads the result.
// Throughput: one pixel at a time; a new beat is taken once the previous pixel ends.
// Reset (arst_n low, asynchronous): registers set to 6 sources, radius 256,
// control idle, no result pending; table and sources hold nothing until loaded.
module wave_interference_pixel_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [wip_pkg::SLOT_W-1:0]    slot,
	input  logic [wip_pkg::HVAL_W-1:0]    height_value,
	input  logic [wip_pkg::COORD_W-1:0]   coord_x,
	input  logic [wip_pkg::COORD_W-1:0]   coord_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wip_pkg::LEVEL_W-1:0]   level,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [wip_pkg::CFG_W-1:0]     cfg_data
);
	import wip_pkg::*;

	state_t             state_q, state_d;
	logic [NSRC_W-1:0]  nsrc_q;
	logic [RAD_W-1:0]   radius_q;
	logic [CNT_W-1:0]   count, left_q;
	logic [SUM_W-1:0]   sum_q;
	logic               hit_s1;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic               acc_in, is_pixel, tbl_we, src_we, out_load;
	logic               root_done, root_hit, sqrt_start;
	logic [ROOT_W-1:0]  root;
	logic [HVAL_W-1:0]  hdata;
	logic [D2_W-1:0]    d2 [MAX_SOURCES+1];
	cell_ctrl_t         cctrl;
	logic [SUM_W+RECIP_SH:0] prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsrc_q   <= NSRC_W'(6);
			radius_q <= RAD_W'(256);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_SOURCES: nsrc_q   <= cfg_data[NSRC_W-1:0];
				CFG_WAVE_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign count = (32'(nsrc_q) > MAX_SOURCES) ? CNT_W'(MAX_SOURCES) : CNT_W'(nsrc_q);

	// input beat decode
	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign is_pixel = acc_in && (action_t'(action) == ACT_PIXEL);
	assign tbl_we   = acc_in && (action_t'(action) == ACT_HEIGHT) && (32'(slot) < TABLE_DEPTH);
	assign src_we   = acc_in && (action_t'(action) == ACT_SOURCE) && (32'(slot) < MAX_SOURCES);

	// cell chain controls
	always_comb begin
		cctrl.calc  = is_pixel;
		cctrl.shift = (state_q == ST_ACC);
		cctrl.px    = coord_x;
		cctrl.py    = coord_y;
	end

	assign d2[MAX_SOURCES] = '0;

	for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
		wip_cell u_cell (
			.clk   (clk),
			.load  (src_we && (32'(slot) == i)),
			.src_x (coord_x),
			.src_y (coord_y),
			.ctrl  (cctrl),
			.d2_in (d2[i+1]),
			.d2    (d2[i])
		);
	end

	// shared root unit on the head of the chain
	assign sqrt_start = (state_q == ST_START);

	wip_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.d2     (d2[0]),
		.done   (root_done),
		.root   (root)
	);

	assign root_hit = (32'(root) < 32'(radius_q)) && (32'(root) < TABLE_DEPTH);

	wip_ram #(.WIDTH(HVAL_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TBL_AW'(slot)),
		.wdata (height_value),
		.re    (root_done),
		.raddr (TBL_AW'(root)),
		.rdata (hdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (is_pixel) state_d = (count == '0) ? ST_FIN : ST_START;
			ST_START: state_d = ST_ROOT;
			ST_ROOT:  if (root_done) state_d = ST_ACC;
			ST_ACC:   state_d = (left_q == CNT_W'(1)) ? ST_FIN : ST_START;
			ST_FIN:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_pixel) begin
				left_q <= count;
			end else if (state_q == ST_ACC) begin
				left_q <= left_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (root_done) begin
			hit_s1 <= root_hit;
		end
		if (is_pixel) begin
			sum_q <= '0;
		end else if (state_q == ST_ACC && hit_s1) begin
			sum_q <= sum_q + SUM_W'(hdata);
		end
	end

	// scale by 2/5 and saturate
	assign prod = (SUM_W+RECIP_SH+1)'({sum_q, 1'b0}) * (SUM_W+RECIP_SH+1)'(RECIP_5);

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (32'(sum_q) >= SAT_SUM) begin
				level_q <= LEVEL_W'(LEVEL_MAX);
			end else begin
				level_q <= prod[RECIP_SH +: LEVEL_W];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

endmodule

FILE: rtl/core/wip_ram.sv
// Generic single-port-write, registered-read RAM.
module wip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/wip_cell.sv
// One source cell: holds a source position and its squared distance to the pixel.
module wip_cell (
	input  logic                          clk,
	input  logic                          load,
	input  logic [wip_pkg::COORD_W-1:0]   src_x,
	input  logic [wip_pkg::COORD_W-1:0]   src_y,
	input  wip_pkg::cell_ctrl_t           ctrl,
	input  logic [wip_pkg::D2_W-1:0]      d2_in,
	output logic [wip_pkg::D2_W-1:0]      d2
);
	import wip_pkg::*;

	logic [COORD_W-1:0] sx_q, sy_q;
	logic [COORD_W-1:0] dx, dy;
	logic [SQ_W-1:0]    dx2, dy2;
	logic [D2_W-1:0]    d2_q;

	// source position
	always_ff @(posedge clk) begin
		if (load) begin
			sx_q <= src_x;
			sy_q <= src_y;
		end
	end

	// absolute differences and squares
	always_comb begin
		dx  = (ctrl.px >= sx_q) ? ctrl.px - sx_q : sx_q - ctrl.px;
		dy  = (ctrl.py >= sy_q) ? ctrl.py - sy_q : sy_q - ctrl.py;
		dx2 = SQ_W'(dx) * SQ_W'(dx);
		dy2 = SQ_W'(dy) * SQ_W'(dy);
	end

	// distance register: load on pixel, pass toward cell 0 on shift
	always_ff @(posedge clk) begin
		if (ctrl.calc) begin
			d2_q <= D2_W'(dx2) + D2_W'(dy2);
		end else if (ctrl.shift) begin
			d2_q <= d2_in;
		end
	end

	assign d2 = d2_q;

endmodule

FILE: rtl/core/wip_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module wip_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wip_pkg::D2_W-1:0]    d2,
	output logic                        done,
	output logic [wip_pkg::ROOT_W-1:0]  root
);
	import wip_pkg::*;

	localparam int RW = D2_W + 1;

	logic [RW-1:0]     v_q, root_q, bit_q, trial;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ROOT_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring root step
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= RW'(d2);
			root_q <= '0;
			bit_q  <= RW'(1) << (2 * (ROOT_W - 1));
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];

endmodule

FILE: rtl/core/wip_checker.sv
// Port-level checker of the wave interference pixel core, bound to the top level.
module wip_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  action,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wip_pkg::LEVEL_W-1:0] level
);
	import wip_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level))
		else $error("result changed while stalled");

	// a pixel beat makes the block busy
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_PIXEL |=> !in_ready)
		else $error("ready after pixel beat");

	// the block is ready again in the cycle after a load beat
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action != ACT_PIXEL |=> in_ready)
		else $error("load beat stalled input");

	// no result while reset is held
	a_reset_out: assert property (@(posedge clk) !arst_n && $past(!arst_n) |-> !out_valid)
		else $error("result during reset");

endmodule

bind wave_interference_pixel_core wip_checker u_wip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level     (level)
);

FILE: test/wave_interference_pixel_core_test.sv
// Testbench for the wave interference pixel core: predicted levels checked beat by beat.
`timescale 1ns / 100ps

module wave_interference_pixel_core_test;
	import wip_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           action;
	logic [SLOT_W-1:0]    slot;
	logic [HVAL_W-1:0]    height_value;
	logic [COORD_W-1:0]   coord_x;
	logic [COORD_W-1:0]   coord_y;
	logic                 out_valid;
	logic                 out_ready;
	logic [LEVEL_W-1:0]   level;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predictor state
	logic [HVAL_W-1:0]    heights [TABLE_DEPTH];
	logic [COORD_W-1:0]   src_x [MAX_SOURCES];
	logic [COORD_W-1:0]   src_y [MAX_SOURCES];
	logic [NSRC_W-1:0]    active_count;
	logic [RAD_W-1:0]     radius;

	logic [LEVEL_W-1:0]   level_queue [$];
	int                   mismatches;
	int                   idle_cycles;
	bit                   timed_out;
	int                   burst_left;

	wave_interference_pixel_core dut (.*);

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Floor integer square root
	function automatic int unsigned floor_root(input int unsigned v);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic logic [LEVEL_W-1:0] predict_level(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		int unsigned n, total, dx, dy, d;
		n = (active_count > MAX_SOURCES) ? MAX_SOURCES : active_count;
		total = 0;
		for (int i = 0; i < n; i++) begin
			dx = (px >= src_x[i]) ? px - src_x[i] : src_x[i] - px;
			dy = (py >= src_y[i]) ? py - src_y[i] : src_y[i] - py;
			d = floor_root(dx * dx + dy * dy);
			if (d < radius && d < TABLE_DEPTH)
				total += heights[d];
		end
		total = (2 * total) / 5;
		return (total > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(total);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatches++;
	endtask

	// Send one beat; sender gaps come between bursts
	task automatic send_beat(input action_t act, input int s, input int h,
			input int x, input int y);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid     <= 1'b1;
		action       <= act;
		slot         <= SLOT_W'(s);
		height_value <= HVAL_W'(h);
		coord_x      <= COORD_W'(x);
		coord_y      <= COORD_W'(y);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		case (act)
			ACT_HEIGHT: heights[s] = HVAL_W'(h);
			ACT_SOURCE: if (s < MAX_SOURCES) begin
				src_x[s] = COORD_W'(x);
				src_y[s] = COORD_W'(y);
			end
			ACT_PIXEL: level_queue.push_back(predict_level(COORD_W'(x), COORD_W'(y)));
			default: ;
		endcase
		burst_left--;
		@(negedge clk);
	endtask

	// Drain results and let the block settle before a register write
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (level_queue.size() != 0) @(negedge clk);
		repeat (130) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_NUM_SOURCES: active_count = NSRC_W'(value);
			CFG_WAVE_RADIUS: radius = RAD_W'(value);
			default:         ;
		endcase
	endtask

	// Loads every table entry and source so nothing undefined is ever read
	task automatic test_load_all();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(ACT_HEIGHT, i, (i % 3 == 0) ? 511 : $urandom_range(0, 511), 0, 0);
		for (int i = 0; i < MAX_SOURCES; i++)
			send_beat(ACT_SOURCE, i, 0, $urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	task automatic test_directed();
		send_beat(ACT_SOURCE, 0, 0, 0, 0);
		send_beat(ACT_SOURCE, 1, 0, 1023, 1023);
		send_beat(ACT_SOURCE, 255, 0, 5, 5);            // source slot out of range
		send_beat(ACT_SOURCE, 2, 0, 512, 512);
		send_beat(ACT_NONE, 3, 100, 7, 7);               // unused action
		send_beat(ACT_PIXEL, 0, 0, 0, 0);
		send_beat(ACT_PIXEL, 0, 0, 1023, 1023);
		send_beat(ACT_PIXEL, 0, 0, 1023, 0);
		send_beat(ACT_PIXEL, 0, 0, 512, 512);
		send_beat(ACT_HEIGHT, 0, 0, 0, 0);
		send_beat(ACT_PIXEL, 255, 511, 0, 0);
		send_beat(ACT_HEIGHT, 0, 511, 0, 0);
		send_beat(ACT_PIXEL, 0, 0, 1, 1);
	endtask

	// Sweep register settings, extremes included
	task automatic test_config_sweep();
		int counts [6] = '{1, 8, 0, 15, 9, 3};
		int radii [6]  = '{256, 1, 0, 511, 300, 40};
		for (int k = 0; k < 6; k++) begin
			settle();
			write_reg(CFG_NUM_SOURCES, counts[k]);
			write_reg(CFG_WAVE_RADIUS, radii[k]);
			for (int j = 0; j < 12; j++)
				send_beat(ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
		end
	endtask

	// Random mix: mostly pixels near sources, some loads and noise
	task automatic test_random();
		int pick, s;
		settle();
		write_reg(CFG_NUM_SOURCES, 8);
		write_reg(CFG_WAVE_RADIUS, 256);
		for (int n = 0; n < 1300; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				send_beat(ACT_HEIGHT, $urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			else if (pick < 16)
				send_beat(ACT_SOURCE, $urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			else if (pick < 19)
				send_beat(ACT_NONE, $urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			else if (pick < 70) begin
				s = $urandom_range(0, MAX_SOURCES - 1);
				send_beat(ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 511),
					(src_x[s] + $urandom_range(0, 300)) & 10'h3FF,
					(src_y[s] + $urandom_range(0, 300)) & 10'h3FF);
			end else
				send_beat(ACT_PIXEL, $urandom_range(0, 255), $urandom_range(0, 511),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
		end
	endtask

	// Receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 7) < 5) || (($time / 4000) % 3 == 0);
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (level_queue.size() == 0)
				report_mismatch($sformatf("unexpected level %0d", level));
			else if (level !== level_queue[0]) begin
				report_mismatch($sformatf("level %0d, expected %0d", level, level_queue[0]));
				void'(level_queue.pop_front());
			end else
				void'(level_queue.pop_front());
		end
	end

	// Watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000 && !timed_out) begin
			timed_out = 1'b1;
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_NONE;
		slot         = '0;
		height_value = '0;
		coord_x      = '0;
		coord_y      = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_NUM_SOURCES;
		cfg_data     = '0;
		mismatches   = 0;
		idle_cycles  = 0;
		timed_out    = 1'b0;
		burst_left   = 0;
		active_count = 6;
		radius       = 256;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_all();
		test_directed();
		test_config_sweep();
		test_random();

		// Drain with a limit
		in_valid <= 1'b0;
		fork
			while (level_queue.size() != 0) @(negedge clk);
			repeat (200000) @(negedge clk);
		join_any
		disable fork;
		repeat (150) @(negedge clk);
		if (mismatches == 0 && level_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
